FILE: rtl/pointer_freeze_pixel_effect_macros.svh
// Assertion macros for the RTL of the pointer freeze pixel effect.
`ifndef POINTER_FREEZE_PIXEL_EFFECT_MACROS_SVH
`define POINTER_FREEZE_PIXEL_EFFECT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PFPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PFPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/pfpe_pkg.sv
// Package: widths, constants and helpers of the pointer freeze pixel effect.
package pfpe_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PLANES     = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LA_W       = COL_W + ROW_W;
    localparam int FA_W       = LA_W + 2;
    localparam int DIM_W      = 9;
    localparam int CD_W       = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_W   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_H   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_H = 2'd3;

    localparam logic [1:0] BTN_HELD  = 2'd1;
    localparam logic [1:0] BTN_PRESS = 2'd2;
    localparam logic [7:0] BASE_PRESS = 8'd100;
    localparam logic [7:0] BASE_HELD  = 8'd50;
    localparam int RAD_DIV = 15;
    // x / 15 as (x * 137) >> 11, exact for x up to MAX_WIDTH
    localparam int RAD_RECIP = 137;
    localparam int RAD_SHIFT = 11;

    // Clamp a register to 1..max.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > mx) r = mx;
        return r;
    endfunction
endpackage

FILE: rtl/pfpe_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface pfpe_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic [1:0]          plane;
    logic [7:0]          row;
    logic [7:0]          col;
    logic [7:0]          pixel_value;
    logic                frame_last;
    logic signed [9:0]   pointer_x;
    logic signed [9:0]   pointer_y;
    logic [1:0]          button_state;
    modport source (output valid, func, plane, row, col, pixel_value, frame_last,
                    pointer_x, pointer_y, button_state, input ready);
    modport sink (input valid, func, plane, row, col, pixel_value, frame_last,
                  pointer_x, pointer_y, button_state, output ready);
endinterface

interface pfpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       frozen;
    modport source (output valid, pixel_out, frozen, input ready);
    modport sink (input valid, pixel_out, frozen, output ready);
endinterface

interface pfpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/pfpe_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module pfpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/pfpe_div.sv
// Restoring divider: quotient of a 16-bit dividend by a 9-bit divisor.
module pfpe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [8:0]  i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [15:0] r_quo, n_quo;
    logic [9:0]  r_rem, n_rem;
    logic [8:0]  r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [9:0]  w_try;

    always_comb begin
        w_try = {r_rem[8:0], r_quo[15]};
        n_rem = w_try;
        n_quo = {r_quo[14:0], 1'b0};
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end
    assign o_quo = r_quo;
endmodule

FILE: rtl/pointer_freeze_pixel_effect.sv
// Top level of the pointer freeze pixel effect.
// Pointer freeze pixel effect. A pixel request passes from idle through a state
// that checks the plane bounds, then two 16-step restoring divisions (row and
// column scaling onto the luma grid) run one after another, then the
// registered read of the countdown/mark memory and the frozen-sample cache, a
// state that writes the cache, and one that loads the output register. A
// pointer request inside the luma area, with the button pressed or held and
// after a first pixel request, walks all luma positions of the visible area,
// one position per cycle, with a read/modify/write pipeline on the countdown
// memory. The last pixel of a frame triggers a similar sweep that decrements
// countdowns and clears marks. After reset a clearing pass zeroes the
// countdown memory; no request is taken meanwhile (configuration writes are).
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a second result stalls in the output state until
// the first one is taken.
module pointer_freeze_pixel_effect (
    input logic i_clk,
    input logic i_rst_n,
    pfpe_in_if.sink    in_ch,
    pfpe_out_if.source out_ch,
    pfpe_cfg_if.sink   cfg_ch
);
    import pfpe_pkg::*;
    `include "pointer_freeze_pixel_effect_macros.svh"

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIVR  = 4'd2;
    localparam logic [3:0] S_DIVC  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_SWEEP = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_RADM  = 4'd8;

    localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT);

    // Countdown memory entry: mark bit plus countdown.
    localparam int CM_W = CD_W + 1;

    logic [3:0]       r_state;
    logic [DIM_W-1:0] r_lw, r_lh, r_cw, r_ch;
    logic             r_seen;
    // latched request
    logic [1:0]       r_plane;
    logic [7:0]       r_row, r_col, r_pix;
    logic             r_last, r_inside;
    logic signed [9:0] r_px, r_py;
    logic [7:0]       r_base;
    logic             r_ptr;       // sweep applies pointer, else frame end
    logic [15:0]      r_rad;
    logic [ROW_W-1:0] r_yr;
    // sweep pipeline
    logic [LA_W:0]    r_sa;        // sweep address with end bit
    logic [ROW_W:0]   r_sr;
    logic [COL_W:0]   r_sc;
    logic             r_v1;
    logic [LA_W-1:0]  r_a1;
    logic [ROW_W:0]   r_r1;
    logic [COL_W:0]   r_c1;
    // output register
    logic             r_ov;
    logic [7:0]       r_opix;
    logic             r_ofz;

    logic [DIM_W-1:0] w_lw, w_lh, w_cw, w_ch, w_pw, w_ph;
    assign w_lw = clamp_dim(r_lw, MAXW);
    assign w_lh = clamp_dim(r_lh, MAXH);
    assign w_cw = clamp_dim(r_cw, MAXW);
    assign w_ch = clamp_dim(r_ch, MAXH);
    assign w_pw = (r_plane == 2'd0) ? w_lw : w_cw;
    assign w_ph = (r_plane == 2'd0) ? w_lh : w_ch;

    // radius term (lw/15)^2 by reciprocal multiplication
    logic [15:0] w_rprod;
    logic [4:0]  w_rq;
    assign w_rprod = 16'(w_lw) * 16'(RAD_RECIP);
    assign w_rq    = 5'(w_rprod >> RAD_SHIFT);

    // divider
    logic        w_dstart, w_ddone;
    logic [15:0] w_dnum, w_dquo;
    logic [8:0]  w_dden;
    pfpe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_dquo)
    );

    // memories
    logic            w_cm_we;
    logic [LA_W-1:0] w_cm_wa, w_cm_ra;
    logic [CM_W-1:0] w_cm_wd, w_cm_rd;
    pfpe_ram #(.WIDTH(CM_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_cd_ram (
        .i_clk(i_clk), .i_we(w_cm_we), .i_waddr(w_cm_wa), .i_wdata(w_cm_wd),
        .i_raddr(w_cm_ra), .o_rdata(w_cm_rd)
    );
    logic            w_fz_we;
    logic [FA_W-1:0] w_fa;
    logic [7:0]      w_fz_rd;
    pfpe_ram #(.WIDTH(8), .DEPTH(PLANES * MAX_WIDTH * MAX_HEIGHT)) u_fz_ram (
        .i_clk(i_clk), .i_we(w_fz_we), .i_waddr(w_fa), .i_wdata(r_pix),
        .i_raddr(w_fa), .o_rdata(w_fz_rd)
    );
    assign w_fa = {r_plane, r_row[ROW_W-1:0], r_col[COL_W-1:0]};

    logic w_in_acc, w_out_free;
    assign w_out_free = !r_ov || out_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);
    assign w_in_acc = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ov;
    assign out_ch.pixel_out = r_opix;
    assign out_ch.frozen = r_ofz;

    // pointer distance for the sweep entry in stage 1
    logic signed [10:0] w_dx, w_dy;
    logic [21:0]        w_dsq;
    logic signed [23:0] w_d;
    logic [7:0]         w_t;
    logic [CD_W-1:0]    w_cd;
    logic               w_mk;
    always_comb begin
        w_dx  = 11'(r_px) - $signed({2'b0, r_c1});
        w_dy  = 11'(r_py) - $signed({2'b0, r_r1});
        w_dsq = 22'(w_dx * w_dx) + 22'(w_dy * w_dy);
        w_d   = $signed({2'b0, w_dsq}) - $signed({8'b0, r_rad});
        if (w_d < 0) w_d = '0;
        if (w_d >= $signed({16'b0, r_base})) w_t = '0;
        else w_t = r_base - w_d[7:0];
        w_cd = w_cm_rd[CD_W-1:0];
        w_mk = w_cm_rd[CD_W];
        if (r_ptr) begin
            if (w_cd == '0 && w_t != '0) w_mk = 1'b1;
            if ({1'b0, w_cd} < w_t) w_cd = w_t[CD_W-1:0];
        end else begin
            if (w_cd != '0) w_cd = w_cd - CD_W'(1);
            w_mk = 1'b0;
        end
    end

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = {8'b0, r_row} * {7'b0, w_lh};
        w_dden   = w_ph;
        if (r_state == S_IDLE && w_in_acc && !in_ch.func) w_dstart = 1'b0;
        if (r_state == S_RADM) begin
            w_dstart = 1'b1;
            w_dnum = {8'b0, r_row} * {7'b0, w_lh};
        end
        if (r_state == S_DIVR && w_ddone) begin
            w_dstart = 1'b1;
            w_dnum = {8'b0, r_col} * {7'b0, w_lw};
            w_dden = w_pw;
        end
        w_cm_we = 1'b0;
        w_cm_wa = r_a1;
        w_cm_wd = {w_mk, w_cd};
        w_cm_ra = r_sa[LA_W-1:0];
        if (r_state == S_CLEAR) begin
            w_cm_we = 1'b1;
            w_cm_wa = r_sa[LA_W-1:0];
            w_cm_wd = '0;
        end else if (r_state == S_SWEEP) begin
            w_cm_we = r_v1;
        end else if (r_state == S_DIVC || r_state == S_RD || r_state == S_WB
                     || r_state == S_OUT) begin
            // column quotient holds in the divider until the next start
            w_cm_ra = {r_yr, w_dquo[COL_W-1:0]};
        end
        w_fz_we = (r_state == S_WB) && r_inside && w_cm_rd[CD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_lw <= 9'd256; r_lh <= 9'd256; r_cw <= 9'd128; r_ch <= 9'd128;
            r_seen <= 1'b0;
            r_sa <= '0;
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                unique case (cfg_ch.index)
                    CFG_LUMA_W:   r_lw <= cfg_ch.data;
                    CFG_LUMA_H:   r_lh <= cfg_ch.data;
                    CFG_CHROMA_W: r_cw <= cfg_ch.data;
                    CFG_CHROMA_H: r_ch <= cfg_ch.data;
                    default: ;
                endcase
            end
            // output state reloads the register itself
            if (r_ov && out_ch.ready && r_state != S_OUT) r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_sa <= r_sa + 1'b1;
                    if (r_sa[LA_W-1:0] == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_plane <= in_ch.plane; r_row <= in_ch.row;
                        r_col <= in_ch.col; r_pix <= in_ch.pixel_value;
                        r_last <= in_ch.frame_last;
                        r_px <= in_ch.pointer_x; r_py <= in_ch.pointer_y;
                        r_base <= (in_ch.button_state == BTN_PRESS) ? BASE_PRESS
                                                                    : BASE_HELD;
                        r_sa <= '0; r_sr <= '0; r_sc <= '0; r_v1 <= 1'b0;
                        if (in_ch.func) begin
                            r_ptr <= 1'b1;
                            r_rad <= 16'(w_rq) * 16'(w_rq);
                            if (r_seen && !in_ch.pointer_x[9] && !in_ch.pointer_y[9]
                                && {1'b0, in_ch.pointer_x[8:0]} < {1'b0, w_lw}
                                && {1'b0, in_ch.pointer_y[8:0]} < {1'b0, w_lh}
                                && (in_ch.button_state == BTN_PRESS
                                    || in_ch.button_state == BTN_HELD))
                                r_state <= S_SWEEP;
                        end else begin
                            r_seen <= 1'b1;
                            r_ptr <= 1'b0;
                            r_state <= S_RADM;
                        end
                    end
                end
                S_RADM: begin
                    r_inside <= (r_plane != 2'd3) && ({1'b0, r_row} < w_ph)
                                && ({1'b0, r_col} < w_pw);
                    r_state <= S_DIVR;
                end
                S_DIVR: if (w_ddone) begin
                    r_yr <= w_dquo[ROW_W-1:0];
                    r_state <= S_DIVC;
                end
                S_DIVC: if (w_ddone) r_state <= S_RD;
                S_RD: r_state <= S_WB;
                S_WB: r_state <= S_OUT;
                S_OUT: if (w_out_free) begin
                    r_ov <= 1'b1;
                    if (r_inside && w_cm_rd[CD_W-1:0] > CD_W'(1)) begin
                        r_opix <= w_cm_rd[CD_W] ? r_pix : w_fz_rd;
                        r_ofz <= 1'b1;
                    end else begin
                        r_opix <= r_pix;
                        r_ofz <= 1'b0;
                    end
                    r_state <= r_last ? S_SWEEP : S_IDLE;
                end
                S_SWEEP: begin
                    // stage 0: issue read; stage 1: modify and write back
                    r_v1 <= !r_sa[LA_W];
                    r_a1 <= r_sa[LA_W-1:0];
                    r_r1 <= r_sr;
                    r_c1 <= r_sc;
                    if (!r_sa[LA_W]) begin
                        if ({1'b0, r_sc} + 10'd1 >= {1'b0, w_lw}) begin
                            r_sc <= '0;
                            r_sr <= r_sr + 1'b1;
                            if ({1'b0, r_sr} + 10'd1 >= {1'b0, w_lh})
                                r_sa <= {1'b1, {LA_W{1'b0}}};
                            else
                                r_sa <= {1'b0, r_sr[ROW_W-1:0] + 1'b1, {COL_W{1'b0}}};
                        end else begin
                            r_sc <= r_sc + 1'b1;
                            r_sa <= r_sa + 1'b1;
                        end
                    end else if (!r_v1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PFPE_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_ch.ready)
    `PFPE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ov && !out_ch.ready,
                     r_ov && $stable(r_opix) && $stable(r_ofz))
    `PFPE_ASSERT_NXT(a_clear_done, i_clk, i_rst_n,
                     r_state == S_CLEAR && r_sa[LA_W-1:0] == '1, r_state == S_IDLE)
    `PFPE_ASSERT_IMP(a_fz_write_inside, i_clk, i_rst_n, w_fz_we, r_inside)
endmodule
